[hw/rtl/aac_pkg.sv]
`timescale 1ns / 1ps

package aac_pkg;

    // Window capacity default, in samples.
    localparam int MAX_WINDOW_SAMPLES_DEF = 1024;

    // Operation codes of an input item.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CLOSE  = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_CLASSIFIED = 2'd0;
    localparam logic [1:0] KIND_DISCARDED  = 2'd1;
    localparam logic [1:0] KIND_REPORT     = 2'd2;

    // Activity classes.
    localparam logic [1:0] CLASS_CALM = 2'd0;
    localparam logic [1:0] CLASS_EAT  = 2'd1;
    localparam logic [1:0] CLASS_WALK = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_CALM_LIMIT     = 2'd0;
    localparam logic [1:0] REG_WALK_LIMIT     = 2'd1;
    localparam logic [1:0] REG_TILT_LIMIT     = 2'd2;
    localparam logic [1:0] REG_WINDOW_SECONDS = 2'd3;

    // Configuration reset values: 0.03 g^2, 0.18 g^2 and 0.4 g in sensor counts.
    localparam logic [31:0] CALM_LIMIT_RST     = 32'd2015587;
    localparam logic [31:0] WALK_LIMIT_RST     = 32'd12093523;
    localparam logic [15:0] TILT_LIMIT_RST     = 16'd3278;
    localparam logic [7:0]  WINDOW_SECONDS_RST = 8'd20;

    // Change sum width and saturation level.
    localparam int          SUM_W   = 42;
    localparam logic [41:0] SUM_MAX = {SUM_W{1'b1}};

    // Z extreme reset values.
    localparam logic signed [15:0] Z_LOW_RST  = 16'sh7FFF;
    localparam logic signed [15:0] Z_HIGH_RST = 16'sh8000;

    // Seconds to minutes: (t + 30) / 60 is ((t + 30) >> 2) / 15, and the
    // division by 15 is a multiply by ceil(2^18 / 15) then a shift by 18,
    // exact for all quotients in range.
    localparam logic [16:0] MIN_ROUND = 17'd30;
    localparam logic [14:0] RECIP_15  = 15'd17477;

    function automatic logic [7:0] to_minutes(input logic [15:0] t);
        logic [16:0] v;
        logic [14:0] w;
        logic [29:0] p;
        logic [11:0] q;
        v = {1'b0, t} + MIN_ROUND;
        w = v[16:2];
        p = 30'(w) * 30'(RECIP_15);
        q = p[29:18];
        return (q > 12'd255) ? 8'hFF : q[7:0];
    endfunction

endpackage

[hw/rtl/accel_activity_classifier.sv]
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid / in_stall       op, accel_x, accel_y, accel_z
// output    out_valid / out_stall     kind, activity_class, calm/eat/walk_minutes
// config    cfg_write                 cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low. Stage one squares and
// sums the axes into a registered energy; stage two updates the window state
// and loads the result register, so a result passes the stage one registers
// and then the result register before it is offered.
// Reset clears the window, the seconds counters and loads the default limits.
// A waiting result holds stage two only for items that produce a result;
// samples keep flowing, and in_stall rises only when stage one is blocked.

module accel_activity_classifier #(
    parameter int MAX_WINDOW_SAMPLES = aac_pkg::MAX_WINDOW_SAMPLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [1:0]         activity_class,
    output logic [7:0]         calm_minutes,
    output logic [7:0]         eat_minutes,
    output logic [7:0]         walk_minutes,

    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CNT_W  = $clog2(MAX_WINDOW_SAMPLES + 1);
    localparam int PROD_W = 32 + CNT_W;
    localparam int CMP_W  = (PROD_W > aac_pkg::SUM_W) ? PROD_W : aac_pkg::SUM_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW_SAMPLES);

    // Configuration registers.
    logic [31:0] calm_limit_reg;
    logic [31:0] walk_limit_reg;
    logic [15:0] tilt_limit_reg;
    logic [7:0]  window_seconds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calm_limit_reg     <= aac_pkg::CALM_LIMIT_RST;
            walk_limit_reg     <= aac_pkg::WALK_LIMIT_RST;
            tilt_limit_reg     <= aac_pkg::TILT_LIMIT_RST;
            window_seconds_reg <= aac_pkg::WINDOW_SECONDS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                aac_pkg::REG_CALM_LIMIT:     calm_limit_reg     <= cfg_data;
                aac_pkg::REG_WALK_LIMIT:     walk_limit_reg     <= cfg_data;
                aac_pkg::REG_TILT_LIMIT:     tilt_limit_reg     <= cfg_data[15:0];
                aac_pkg::REG_WINDOW_SECONDS: window_seconds_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Stage one: squared magnitude of the incoming sample.
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic signed [31:0] sq_z;
    logic [31:0]        energy_in;

    assign sq_x      = 32'(accel_x) * 32'(accel_x);
    assign sq_y      = 32'(accel_y) * 32'(accel_y);
    assign sq_z      = 32'(accel_z) * 32'(accel_z);
    assign energy_in = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [1:0]         s1_op_reg;
    logic [31:0]        s1_energy_reg;
    logic signed [15:0] s1_z_reg;

    // Handshake control between the stages.
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic s1_has_result;
    logic s2_go;
    logic in_accept;

    assign out_free      = !out_valid_reg || !out_stall;
    assign s1_has_result = (s1_op_reg == aac_pkg::OP_CLOSE) || (s1_op_reg == aac_pkg::OP_REPORT);
    assign s2_go         = s1_valid_reg && (!s1_has_result || out_free);
    assign in_stall      = s1_valid_reg && !s2_go;
    assign in_accept     = in_valid && !in_stall;
    assign s1_valid_next = in_accept ? 1'b1 : (s2_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= op;
            s1_energy_reg <= energy_in;
            s1_z_reg      <= accel_z;
        end
    end

    // Window and counter state.
    logic [31:0]              prev_energy_reg, prev_energy_next;
    logic [aac_pkg::SUM_W-1:0] change_sum_reg, change_sum_next;
    logic [CNT_W-1:0]         sample_count_reg, sample_count_next;
    logic signed [15:0]       z_low_reg, z_low_next;
    logic signed [15:0]       z_high_reg, z_high_next;
    logic [15:0]              calm_time_reg, calm_time_next;
    logic [15:0]              eat_time_reg, eat_time_next;
    logic [15:0]              walk_time_reg, walk_time_next;

    // Result register.
    logic [1:0] kind_reg, kind_next;
    logic [1:0] class_reg, class_next;
    logic [7:0] rpt_calm_reg, rpt_calm_next;
    logic [7:0] rpt_eat_reg, rpt_eat_next;
    logic [7:0] rpt_walk_reg, rpt_walk_next;

    // Sample path: energy change and saturating sum.
    logic [31:0]               delta;
    logic [aac_pkg::SUM_W:0]   sum_wide;
    logic [aac_pkg::SUM_W-1:0] sum_sat;

    assign delta    = (s1_energy_reg > prev_energy_reg) ? s1_energy_reg - prev_energy_reg
                                                        : prev_energy_reg - s1_energy_reg;
    assign sum_wide = {1'b0, change_sum_reg} + (aac_pkg::SUM_W + 1)'(delta);
    assign sum_sat  = (sum_wide > {1'b0, aac_pkg::SUM_MAX}) ? aac_pkg::SUM_MAX
                                                            : sum_wide[aac_pkg::SUM_W-1:0];

    // Close path: mean compared as sum against limit times (count - 1).
    logic [CNT_W-1:0]   n1;
    logic [PROD_W-1:0]  calm_prod;
    logic [PROD_W-1:0]  walk_prod;
    logic [CMP_W-1:0]   sum_cmp;
    logic signed [17:0] z_range;
    logic               tilted;
    logic [1:0]         cls;

    assign n1        = sample_count_reg - CNT_W'(1);
    assign calm_prod = PROD_W'(calm_limit_reg) * PROD_W'(n1);
    assign walk_prod = PROD_W'(walk_limit_reg) * PROD_W'(n1);
    assign sum_cmp   = CMP_W'(change_sum_reg);
    assign z_range   = 18'(z_high_reg) - 18'(z_low_reg);
    assign tilted    = z_range > $signed({2'b00, tilt_limit_reg});

    always_comb
    begin
        if (sum_cmp < CMP_W'(calm_prod))
        begin
            cls = aac_pkg::CLASS_CALM;
        end
        else if (sum_cmp <= CMP_W'(walk_prod))
        begin
            cls = tilted ? aac_pkg::CLASS_CALM : aac_pkg::CLASS_EAT;
        end
        else
        begin
            cls = aac_pkg::CLASS_WALK;
        end
    end

    // Saturating credit of one window to each counter.
    logic [16:0] calm_credit;
    logic [16:0] eat_credit;
    logic [16:0] walk_credit;

    assign calm_credit = {1'b0, calm_time_reg} + 17'(window_seconds_reg);
    assign eat_credit  = {1'b0, eat_time_reg} + 17'(window_seconds_reg);
    assign walk_credit = {1'b0, walk_time_reg} + 17'(window_seconds_reg);

    // Stage two: state update and result formation.
    always_comb
    begin
        prev_energy_next  = prev_energy_reg;
        change_sum_next   = change_sum_reg;
        sample_count_next = sample_count_reg;
        z_low_next        = z_low_reg;
        z_high_next       = z_high_reg;
        calm_time_next    = calm_time_reg;
        eat_time_next     = eat_time_reg;
        walk_time_next    = walk_time_reg;
        kind_next         = kind_reg;
        class_next        = class_reg;
        rpt_calm_next     = rpt_calm_reg;
        rpt_eat_next      = rpt_eat_reg;
        rpt_walk_next     = rpt_walk_reg;

        if (s2_go)
        begin
            unique case (s1_op_reg)
                aac_pkg::OP_SAMPLE:
                begin
                    if (sample_count_reg < CNT_MAX)
                    begin
                        if (s1_z_reg < z_low_reg)
                        begin
                            z_low_next = s1_z_reg;
                        end
                        if (s1_z_reg > z_high_reg)
                        begin
                            z_high_next = s1_z_reg;
                        end
                        if (sample_count_reg != '0)
                        begin
                            change_sum_next = sum_sat;
                        end
                        prev_energy_next  = s1_energy_reg;
                        sample_count_next = sample_count_reg + CNT_W'(1);
                    end
                end
                aac_pkg::OP_CLOSE:
                begin
                    rpt_calm_next = '0;
                    rpt_eat_next  = '0;
                    rpt_walk_next = '0;
                    if (sample_count_reg < CNT_W'(2))
                    begin
                        kind_next  = aac_pkg::KIND_DISCARDED;
                        class_next = '0;
                    end
                    else
                    begin
                        kind_next  = aac_pkg::KIND_CLASSIFIED;
                        class_next = cls;
                        case (cls)
                            aac_pkg::CLASS_CALM:
                                calm_time_next = calm_credit[16] ? 16'hFFFF : calm_credit[15:0];
                            aac_pkg::CLASS_EAT:
                                eat_time_next = eat_credit[16] ? 16'hFFFF : eat_credit[15:0];
                            default:
                                walk_time_next = walk_credit[16] ? 16'hFFFF : walk_credit[15:0];
                        endcase
                    end
                    prev_energy_next  = '0;
                    change_sum_next   = '0;
                    sample_count_next = '0;
                    z_low_next        = aac_pkg::Z_LOW_RST;
                    z_high_next       = aac_pkg::Z_HIGH_RST;
                end
                aac_pkg::OP_REPORT:
                begin
                    kind_next      = aac_pkg::KIND_REPORT;
                    class_next     = '0;
                    rpt_calm_next  = aac_pkg::to_minutes(calm_time_reg);
                    rpt_eat_next   = aac_pkg::to_minutes(eat_time_reg);
                    rpt_walk_next  = aac_pkg::to_minutes(walk_time_reg);
                    calm_time_next = '0;
                    eat_time_next  = '0;
                    walk_time_next = '0;
                end
                default: ;
            endcase
        end
    end

    // Output valid: set by a result, cleared once taken.
    assign out_valid_next = (s2_go && s1_has_result) ? 1'b1 :
                            (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_energy_reg  <= '0;
            change_sum_reg   <= '0;
            sample_count_reg <= '0;
            z_low_reg        <= aac_pkg::Z_LOW_RST;
            z_high_reg       <= aac_pkg::Z_HIGH_RST;
            calm_time_reg    <= '0;
            eat_time_reg     <= '0;
            walk_time_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            prev_energy_reg  <= prev_energy_next;
            change_sum_reg   <= change_sum_next;
            sample_count_reg <= sample_count_next;
            z_low_reg        <= z_low_next;
            z_high_reg       <= z_high_next;
            calm_time_reg    <= calm_time_next;
            eat_time_reg     <= eat_time_next;
            walk_time_reg    <= walk_time_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        class_reg    <= class_next;
        rpt_calm_reg <= rpt_calm_next;
        rpt_eat_reg  <= rpt_eat_next;
        rpt_walk_reg <= rpt_walk_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign activity_class = class_reg;
    assign calm_minutes   = rpt_calm_reg;
    assign eat_minutes    = rpt_eat_reg;
    assign walk_minutes   = rpt_walk_reg;

endmodule
